// ----- design/vrrp_pkg.sv -----
// Package for the virtual-router state machine: types, codes and constants.
`default_nettype none

package vrrp_pkg;

    // Timer ticks per second of advertisement interval
    localparam int unsigned TICKS_PER_SECOND = 256;
    localparam int unsigned TICK_SHIFT       = 8;
    localparam int unsigned TIMER_W          = 18;

    // Router modes
    localparam logic [1:0] ST_INIT   = 2'd0;
    localparam logic [1:0] ST_BACKUP = 2'd1;
    localparam logic [1:0] ST_MASTER = 2'd2;

    // Input operations
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_ADV   = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;
    localparam logic [1:0] OP_STOP  = 2'd3;

    // Error codes of advertisement checks
    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_NOT_RUN  = 3'd1;
    localparam logic [2:0] ERR_AUTH     = 3'd2;
    localparam logic [2:0] ERR_ADDRS    = 3'd3;
    localparam logic [2:0] ERR_INTERVAL = 3'd4;

    // Special priorities
    localparam logic [7:0] PRI_LEAVE = 8'd0;
    localparam logic [7:0] PRI_OWNER = 8'd255;

    // Configuration register indexes
    localparam logic [1:0] REG_LOCAL_PRIORITY  = 2'd0;
    localparam logic [1:0] REG_ADVERT_INTERVAL = 2'd1;
    localparam logic [1:0] REG_PREEMPT_ENABLE  = 2'd2;
    localparam logic [1:0] REG_OWN_ADDR        = 2'd3;

    // Configuration reset values
    localparam logic [7:0]  RST_LOCAL_PRIORITY  = 8'd100;
    localparam logic [7:0]  RST_ADVERT_INTERVAL = 8'd1;
    localparam logic        RST_PREEMPT_ENABLE  = 1'b1;
    localparam logic [31:0] RST_OWN_ADDR        = 32'd0;

    typedef struct packed {
        logic [7:0]  local_priority;
        logic [7:0]  advert_interval;
        logic        preempt_enable;
        logic [31:0] own_addr;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  adv_priority;
        logic [31:0] adv_from;
        logic [7:0]  adv_interval;
        logic        adv_auth_none;
        logic        adv_addrs_match;
        logic        link_ready;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  router_mode;
        logic        send_advert;
        logic [7:0]  sent_priority;
        logic        take_over;
        logic        release_res;
        logic        join_group;
        logic        leave_group;
        logic [2:0]  error_code;
        logic [31:0] master_addr;
    } t_out_word;

endpackage

`default_nettype wire

// ----- design/vrrp_cfg_regs.sv -----
// Configuration register file of the virtual-router state machine.
`default_nettype none

module vrrp_cfg_regs (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [31:0]       i_cfg_data,
    output vrrp_pkg::t_cfg         o_cfg
);

    vrrp_pkg::t_cfg r_cfg;

    // One register written per enabled cycle; all indexes are defined
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.local_priority  <= vrrp_pkg::RST_LOCAL_PRIORITY;
            r_cfg.advert_interval <= vrrp_pkg::RST_ADVERT_INTERVAL;
            r_cfg.preempt_enable  <= vrrp_pkg::RST_PREEMPT_ENABLE;
            r_cfg.own_addr        <= vrrp_pkg::RST_OWN_ADDR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                vrrp_pkg::REG_LOCAL_PRIORITY:  r_cfg.local_priority  <= i_cfg_data[7:0];
                vrrp_pkg::REG_ADVERT_INTERVAL: r_cfg.advert_interval <= i_cfg_data[7:0];
                vrrp_pkg::REG_PREEMPT_ENABLE:  r_cfg.preempt_enable  <= i_cfg_data[0];
                vrrp_pkg::REG_OWN_ADDR:        r_cfg.own_addr        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- design/vrrp_fsm.sv -----
// Router state, timer and the combinational step logic for one word.
`default_nettype none

module vrrp_fsm (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_step,
    input  wire vrrp_pkg::t_in_word  i_word,
    input  wire vrrp_pkg::t_cfg      i_cfg,
    output vrrp_pkg::t_out_word      o_result
);

    localparam int unsigned TW = vrrp_pkg::TIMER_W;

    logic [1:0]    r_state;
    logic [TW-1:0] r_timer_count;
    logic          r_timer_armed;
    logic [31:0]   r_last_master;

    logic [1:0]    n_state;
    logic [TW-1:0] n_timer_count;
    logic          n_timer_armed;
    logic [31:0]   n_last_master;

    logic [7:0]    eff_interval;
    logic [9:0]    triple_interval;
    logic [8:0]    skew;
    logic [TW-1:0] advert_ticks;
    logic [TW-1:0] skew_ticks;
    logic [TW-1:0] master_down_ticks;
    logic [TW-1:0] count_dec;

    logic          send;
    logic [7:0]    sprio;
    logic          take;
    logic          rel;
    logic          join_g;
    logic          leave_g;
    logic [2:0]    err;

    // Timer reload values; a zero interval counts as one second
    always_comb begin
        eff_interval      = (i_cfg.advert_interval == 8'd0) ? 8'd1 : i_cfg.advert_interval;
        triple_interval   = {1'b0, eff_interval, 1'b0} + {2'b00, eff_interval};
        skew              = 9'd256 - {1'b0, i_cfg.local_priority};
        advert_ticks      = {2'b00, eff_interval, 8'd0};
        skew_ticks        = {{(TW-9){1'b0}}, skew};
        master_down_ticks = {triple_interval, 8'd0} + skew_ticks;
        count_dec         = (r_timer_count == '0) ? '0 : r_timer_count - 1'b1;
    end

    // Next state and result for the word in the input register
    always_comb begin
        n_state       = r_state;
        n_timer_count = r_timer_count;
        n_timer_armed = r_timer_armed;
        n_last_master = r_last_master;
        send          = 1'b0;
        sprio         = vrrp_pkg::PRI_LEAVE;
        take          = 1'b0;
        rel           = 1'b0;
        join_g        = 1'b0;
        leave_g       = 1'b0;
        err           = vrrp_pkg::ERR_OK;
        unique case (i_word.op)
            vrrp_pkg::OP_TICK: begin
                if (r_state != vrrp_pkg::ST_INIT && r_timer_armed) begin
                    n_timer_count = count_dec;
                    if (count_dec == '0) begin
                        if (r_state == vrrp_pkg::ST_BACKUP) begin
                            n_state = vrrp_pkg::ST_MASTER;
                            take    = 1'b1;
                        end
                        send          = 1'b1;
                        sprio         = i_cfg.local_priority;
                        n_timer_count = advert_ticks;
                        n_timer_armed = 1'b1;
                    end
                end
            end
            vrrp_pkg::OP_ADV: begin
                if (r_state == vrrp_pkg::ST_INIT) begin
                    err = vrrp_pkg::ERR_NOT_RUN;
                end else if (!i_word.adv_auth_none) begin
                    err = vrrp_pkg::ERR_AUTH;
                end else if (!i_word.adv_addrs_match &&
                             i_word.adv_priority != vrrp_pkg::PRI_OWNER) begin
                    err = vrrp_pkg::ERR_ADDRS;
                end else if (i_word.adv_interval != eff_interval) begin
                    err = vrrp_pkg::ERR_INTERVAL;
                end else if (r_state == vrrp_pkg::ST_BACKUP) begin
                    n_last_master = i_word.adv_from;
                    if (i_word.adv_priority == vrrp_pkg::PRI_LEAVE) begin
                        n_timer_count = skew_ticks;
                        n_timer_armed = 1'b1;
                    end else if (!i_cfg.preempt_enable ||
                                 i_word.adv_priority >= i_cfg.local_priority) begin
                        n_timer_count = master_down_ticks;
                        n_timer_armed = 1'b1;
                    end
                end else begin
                    if (i_word.adv_priority == vrrp_pkg::PRI_LEAVE) begin
                        send          = 1'b1;
                        sprio         = i_cfg.local_priority;
                        n_timer_count = advert_ticks;
                        n_timer_armed = 1'b1;
                    end else if (i_word.adv_priority > i_cfg.local_priority ||
                                 (i_word.adv_priority == i_cfg.local_priority &&
                                  i_word.adv_from > i_cfg.own_addr)) begin
                        rel           = 1'b1;
                        n_state       = vrrp_pkg::ST_BACKUP;
                        n_timer_count = master_down_ticks;
                        n_timer_armed = 1'b1;
                    end
                end
            end
            vrrp_pkg::OP_START: begin
                if (r_state == vrrp_pkg::ST_INIT && i_word.link_ready) begin
                    join_g        = 1'b1;
                    n_timer_armed = 1'b1;
                    if (i_cfg.local_priority == vrrp_pkg::PRI_OWNER) begin
                        n_state       = vrrp_pkg::ST_MASTER;
                        take          = 1'b1;
                        send          = 1'b1;
                        sprio         = i_cfg.local_priority;
                        n_timer_count = advert_ticks;
                    end else begin
                        n_state       = vrrp_pkg::ST_BACKUP;
                        n_timer_count = master_down_ticks;
                    end
                end
            end
            vrrp_pkg::OP_STOP: begin
                if (r_state != vrrp_pkg::ST_INIT) begin
                    leave_g       = 1'b1;
                    n_timer_armed = 1'b0;
                    n_timer_count = '0;
                    if (r_state == vrrp_pkg::ST_MASTER) begin
                        send  = 1'b1;
                        sprio = vrrp_pkg::PRI_LEAVE;
                        rel   = 1'b1;
                    end
                    n_state = vrrp_pkg::ST_INIT;
                end
            end
            default: ;
        endcase
    end

    // State is updated once per word as it leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= vrrp_pkg::ST_INIT;
            r_timer_count <= '0;
            r_timer_armed <= 1'b0;
            r_last_master <= '0;
        end else if (i_step) begin
            r_state       <= n_state;
            r_timer_count <= n_timer_count;
            r_timer_armed <= n_timer_armed;
            r_last_master <= n_last_master;
        end
    end

    // Result word reports the mode after the step
    always_comb begin
        o_result.router_mode   = n_state;
        o_result.send_advert   = send;
        o_result.sent_priority = sprio;
        o_result.take_over     = take;
        o_result.release_res   = rel;
        o_result.join_group    = join_g;
        o_result.leave_group   = leave_g;
        o_result.error_code    = err;
        o_result.master_addr   = (n_state == vrrp_pkg::ST_MASTER) ? i_cfg.own_addr
                                                                  : n_last_master;
    end

endmodule

`default_nettype wire

// ----- design/vrrp_router_state_machine.sv -----
// A word accepted into the input register has its result computed by the step and registered in the result register.
// Throughput: one word per cycle while the output is not stalled, set by the single step between the input and result
// registers; the input register accepts while the result register is drained or empty.
// Reset (synchronous, active low): mode initialize, timer stopped and cleared, last
// master zero, registers to their defaults, both pipeline stages empty.
`default_nettype none

module vrrp_router_state_machine (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire vrrp_pkg::t_in_word   i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output vrrp_pkg::t_out_word       o_out_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [31:0]          i_cfg_data
);

    vrrp_pkg::t_cfg      cfg;
    vrrp_pkg::t_out_word step_result;

    logic                r_in_valid;
    vrrp_pkg::t_in_word  r_in_data;
    logic                r_out_valid;
    vrrp_pkg::t_out_word r_out_data;

    logic                advance;
    logic                step;

    // The step fires when a word waits and the result register can take it
    assign advance    = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    vrrp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    vrrp_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_word   (r_in_data),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire
